// File: rtl/core/cfe_pkg.sv
// Shared constants and types of the column FIR with edge normalisation.
package cfe_pkg;

   // Column geometry
   localparam int MAX_LEVELS = 64;
   localparam int LEVEL_BITS = $clog2(MAX_LEVELS);
   localparam int COUNT_BITS = LEVEL_BITS + 1;

   // Kernel and edge factors
   localparam int MAX_TAPS      = 8;
   localparam int TAP_IDX_BITS  = $clog2(MAX_TAPS);
   localparam int TAP_CNT_BITS  = 4;
   localparam int MAX_EDGE      = 4;
   localparam int EDGE_IDX_BITS = $clog2(MAX_EDGE);
   localparam int NORM_BITS     = 3;
   localparam int PASS_BITS     = $clog2(2 * MAX_EDGE + 1);

   // Arithmetic
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 16;
   localparam int FRAC_BITS   = 14;
   localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS    = PROD_BITS + TAP_IDX_BITS;

   // Register port
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam int NUM_LEVELS_BITS = 7;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ADJOINT_MODE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_LEVELS       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL_SIZE      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NORM_SIZE        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL_TAPS_LOW  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL_TAPS_HIGH = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EDGE_FACTORS     = 3'd6;

   // Column store write port
   typedef struct packed {
      logic                          en;
      logic [LEVEL_BITS-1:0]         addr;
      logic signed [SAMPLE_BITS-1:0] data;
   } store_wr_type;

   // Column store read port
   typedef struct packed {
      logic                  en;
      logic [LEVEL_BITS-1:0] addr;
   } store_rd_type;

   // Multiply-accumulate control
   typedef struct packed {
      logic valid;
      logic start;
   } mac_ctrl_type;

endpackage

// File: rtl/core/cfe_store.sv
// Column store: one write port, one read port with registered read data.
module cfe_store (
   input  logic                                  clock,
   input  cfe_pkg::store_wr_type                 wr,
   input  cfe_pkg::store_rd_type                 rd,
   output logic signed [cfe_pkg::SAMPLE_BITS-1:0] rd_data
);
   import cfe_pkg::*;

   logic signed [SAMPLE_BITS-1:0] mem_ff [MAX_LEVELS];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // read port, registered read data, data holds between reads
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/cfe_mac.sv
// Shared multiply-accumulate unit with round-half-up and saturation.
module cfe_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cfe_pkg::mac_ctrl_type                 ctrl,
   input  logic signed [cfe_pkg::SAMPLE_BITS-1:0] mac_a,
   input  logic signed [cfe_pkg::COEF_BITS-1:0]   mac_b,
   output logic signed [cfe_pkg::SAMPLE_BITS-1:0] result
);
   import cfe_pkg::*;

   localparam logic signed [ACC_BITS:0] ROUND_HALF = (ACC_BITS+1)'(2 ** (FRAC_BITS - 1));
   localparam logic signed [ACC_BITS:0] SAT_HI = (ACC_BITS+1)'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam logic signed [ACC_BITS:0] SAT_LO = -SAT_HI - (ACC_BITS+1)'(1);

   mac_ctrl_type                stage_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic signed [ACC_BITS-1:0]  acc_in;
   logic signed [ACC_BITS:0]    rounded;
   logic signed [ACC_BITS:0]    shifted;

   // product stage
   assign prod_in = mac_a * mac_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= ctrl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // accumulate stage
   always_comb begin
      if (stage_ff.start) begin
         acc_in = ACC_BITS'(prod_ff);
      end else begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // round to nearest, halves up, then clamp to the sample range
   always_comb begin
      rounded = (ACC_BITS+1)'(acc_ff) + ROUND_HALF;
      shifted = rounded >>> FRAC_BITS;
      if (shifted > SAT_HI) begin
         result = SAT_HI[SAMPLE_BITS-1:0];
      end else if (shifted < SAT_LO) begin
         result = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         result = shifted[SAMPLE_BITS-1:0];
      end
   end

endmodule

// File: rtl/core/column_fir_with_edge_norm.sv
// Column FIR with edge normalisation: top level, register port and sequencer.
//
// Samples of one column arrive one per transfer and are written to the column
// store at one per cycle. The transfer that completes the column starts the
// filter pass; the input stalls until the last result of the column has been
// handed to the output register. Each output level is convolved over
// max(kernel_size,1) taps, at most eight, one tap a cycle, set by the single
// read port of the column store feeding the shared multiplier. In forward
// mode a scaling follows for each column edge within norm_size levels, and
// in both modes the result is then handed over. In adjoint mode a pre-pass
// first rescales the up to 2*norm_size edge levels in place, each scaled once or twice.
module column_fir_with_edge_norm (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [cfe_pkg::SAMPLE_BITS-1:0]   req_level_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [cfe_pkg::SAMPLE_BITS-1:0]   rsp_filtered_value,
   output logic                                     rsp_last_of_column,
   input  logic                                     csr_wr_en,
   input  logic [cfe_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [cfe_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);
   import cfe_pkg::*;

   localparam logic [3:0] S_LOAD = 4'd0;
   localparam logic [3:0] S_PSEL = 4'd1;
   localparam logic [3:0] S_PLD  = 4'd2;
   localparam logic [3:0] S_SMUL = 4'd3;
   localparam logic [3:0] S_SACC = 4'd4;
   localparam logic [3:0] S_SRND = 4'd5;
   localparam logic [3:0] S_PWR  = 4'd6;
   localparam logic [3:0] S_CONV = 4'd7;
   localparam logic [3:0] S_CW1  = 4'd8;
   localparam logic [3:0] S_CW2  = 4'd9;
   localparam logic [3:0] S_CRND = 4'd10;
   localparam logic [3:0] S_EMIT = 4'd11;

   // tap in flight between store read and multiplier
   typedef struct packed {
      logic                        valid;
      logic                        start;
      logic                        zero;
      logic signed [COEF_BITS-1:0] coef;
   } tap_tag_type;

   // configuration registers
   logic                          adjoint_mode_ff;
   logic [NUM_LEVELS_BITS-1:0]    num_levels_ff;
   logic [TAP_CNT_BITS-1:0]       kernel_size_ff;
   logic [NORM_BITS-1:0]          norm_size_ff;
   logic [CSR_DATA_BITS-1:0]      kernel_taps_low_ff;
   logic [CSR_DATA_BITS-1:0]      kernel_taps_high_ff;
   logic [CSR_DATA_BITS-1:0]      edge_factors_ff;

   // sequencer state
   logic [3:0]                    state_ff, state_in;
   logic [COUNT_BITS-1:0]         load_count_ff, load_count_in;
   logic [LEVEL_BITS-1:0]         lvl_ff, lvl_in;
   logic [TAP_IDX_BITS-1:0]       k_ff, k_in;
   logic [PASS_BITS-1:0]          pass_ff, pass_in;
   logic                          second_ff, second_in;
   logic signed [SAMPLE_BITS-1:0] val_ff, val_in;
   tap_tag_type                   tag_ff, tag_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                          rsp_last_ff, rsp_last_in;

   // derived values
   logic [COUNT_BITS-1:0]         n_eff;
   logic [TAP_CNT_BITS-1:0]       ks_eff;
   logic [NORM_BITS-1:0]          ns_eff;
   logic [COUNT_BITS-1:0]         ns_wide;
   logic [TAP_IDX_BITS-1:0]       k_last;
   logic [TAP_IDX_BITS-1:0]       ctr;
   logic [COUNT_BITS:0]           src;
   logic                          src_ok;
   logic signed [COEF_BITS-1:0]   tap_coef;
   logic [2*CSR_DATA_BITS-1:0]    tap_bank;
   logic [COUNT_BITS-1:0]         mirror;
   logic [COUNT_BITS-1:0]         j_near, j_far;
   logic                          need_first, need_second;
   logic [EDGE_IDX_BITS-1:0]      fac_idx;
   logic signed [COEF_BITS-1:0]   factor;
   logic                          lvl_is_last;
   logic [COUNT_BITS-1:0]         pass_wide, pass_q, pass_hi;
   logic                          pass_low, pass_ok, pass_done;
   logic [LEVEL_BITS-1:0]         pass_lvl;

   // datapath links
   store_wr_type                  st_wr;
   store_rd_type                  st_rd;
   logic signed [SAMPLE_BITS-1:0] st_rd_data;
   mac_ctrl_type                  mac_ctrl;
   logic signed [SAMPLE_BITS-1:0] mac_a;
   logic signed [COEF_BITS-1:0]   mac_b;
   logic signed [SAMPLE_BITS-1:0] mac_result;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         adjoint_mode_ff     <= 1'b0;
         num_levels_ff       <= NUM_LEVELS_BITS'(MAX_LEVELS);
         kernel_size_ff      <= TAP_CNT_BITS'(1);
         norm_size_ff        <= '0;
         kernel_taps_low_ff  <= '0;
         kernel_taps_high_ff <= '0;
         edge_factors_ff     <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ADJOINT_MODE:     adjoint_mode_ff     <= csr_wdata[0];
            CSR_NUM_LEVELS:       num_levels_ff       <= csr_wdata[NUM_LEVELS_BITS-1:0];
            CSR_KERNEL_SIZE:      kernel_size_ff      <= csr_wdata[TAP_CNT_BITS-1:0];
            CSR_NORM_SIZE:        norm_size_ff        <= csr_wdata[NORM_BITS-1:0];
            CSR_KERNEL_TAPS_LOW:  kernel_taps_low_ff  <= csr_wdata;
            CSR_KERNEL_TAPS_HIGH: kernel_taps_high_ff <= csr_wdata;
            CSR_EDGE_FACTORS:     edge_factors_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp the register values to the supported ranges
   always_comb begin
      if (num_levels_ff == '0) begin
         n_eff = COUNT_BITS'(1);
      end else if (num_levels_ff > NUM_LEVELS_BITS'(MAX_LEVELS)) begin
         n_eff = COUNT_BITS'(MAX_LEVELS);
      end else begin
         n_eff = COUNT_BITS'(num_levels_ff);
      end
      if (kernel_size_ff > TAP_CNT_BITS'(MAX_TAPS)) begin
         ks_eff = TAP_CNT_BITS'(MAX_TAPS);
      end else begin
         ks_eff = kernel_size_ff;
      end
      if (norm_size_ff > NORM_BITS'(MAX_EDGE)) begin
         ns_eff = NORM_BITS'(MAX_EDGE);
      end else begin
         ns_eff = norm_size_ff;
      end
      ns_wide = COUNT_BITS'(ns_eff);
      // no taps still runs one tap, zeroed
      if (ks_eff == '0) begin
         k_last = '0;
         ctr    = '0;
      end else begin
         k_last = TAP_IDX_BITS'(ks_eff - TAP_CNT_BITS'(1));
         ctr    = TAP_IDX_BITS'((ks_eff - TAP_CNT_BITS'(1)) >> 1);
      end
   end

   // source level of the current tap, zero outside the column
   assign src = (COUNT_BITS+1)'(lvl_ff) + (COUNT_BITS+1)'(ctr) - (COUNT_BITS+1)'(k_ff);
   assign src_ok = !src[COUNT_BITS] && (src[COUNT_BITS-1:0] < n_eff);
   assign tap_bank = {kernel_taps_high_ff, kernel_taps_low_ff};
   assign tap_coef = tap_bank[k_ff*COEF_BITS +: COEF_BITS];

   // edge factors for the current level: nearer edge first, then the farther one
   always_comb begin
      mirror = n_eff - COUNT_BITS'(1) - COUNT_BITS'(lvl_ff);
      if (COUNT_BITS'(lvl_ff) <= mirror) begin
         j_near = COUNT_BITS'(lvl_ff);
         j_far  = mirror;
      end else begin
         j_near = mirror;
         j_far  = COUNT_BITS'(lvl_ff);
      end
      need_first  = j_near < ns_wide;
      need_second = j_far < ns_wide;
      fac_idx     = second_ff ? j_far[EDGE_IDX_BITS-1:0] : j_near[EDGE_IDX_BITS-1:0];
      factor      = edge_factors_ff[fac_idx*COEF_BITS +: COEF_BITS];
   end

   assign lvl_is_last = COUNT_BITS'(lvl_ff) == (n_eff - COUNT_BITS'(1));

   // pre-pass level selection: low edge first, then high edge without repeats
   always_comb begin
      pass_wide = COUNT_BITS'(pass_ff);
      pass_low  = pass_wide < ns_wide;
      pass_q    = pass_wide - ns_wide;
      pass_hi   = n_eff - COUNT_BITS'(1) - pass_q;
      pass_done = pass_wide == (ns_wide << 1);
      if (pass_low) begin
         pass_ok  = pass_wide < n_eff;
         pass_lvl = pass_wide[LEVEL_BITS-1:0];
      end else begin
         pass_ok  = (pass_q < n_eff) && (pass_hi >= ns_wide);
         pass_lvl = pass_hi[LEVEL_BITS-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      lvl_in        = lvl_ff;
      k_in          = k_ff;
      pass_in       = pass_ff;
      second_in     = second_ff;
      val_in        = val_ff;
      tag_in        = '0;
      st_wr         = '0;
      st_rd         = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               st_wr.en   = 1'b1;
               st_wr.addr = load_count_ff[LEVEL_BITS-1:0];
               st_wr.data = req_level_value;
               if ((load_count_ff + COUNT_BITS'(1)) < n_eff) begin
                  load_count_in = load_count_ff + COUNT_BITS'(1);
               end else begin
                  load_count_in = '0;
                  lvl_in        = '0;
                  k_in          = '0;
                  pass_in       = '0;
                  second_in     = 1'b0;
                  state_in      = adjoint_mode_ff ? S_PSEL : S_CONV;
               end
            end
         end
         S_PSEL: begin
            if (pass_done) begin
               lvl_in   = '0;
               k_in     = '0;
               state_in = S_CONV;
            end else if (pass_ok) begin
               st_rd.en   = 1'b1;
               st_rd.addr = pass_lvl;
               lvl_in     = pass_lvl;
               state_in   = S_PLD;
            end else begin
               pass_in = pass_ff + PASS_BITS'(1);
            end
         end
         S_PLD: begin
            val_in    = st_rd_data;
            second_in = 1'b0;
            state_in  = S_SMUL;
         end
         S_SMUL: begin
            state_in = S_SACC;
         end
         S_SACC: begin
            state_in = S_SRND;
         end
         S_SRND: begin
            val_in = mac_result;
            if (!second_ff && need_second) begin
               second_in = 1'b1;
               state_in  = S_SMUL;
            end else begin
               second_in = 1'b0;
               state_in  = adjoint_mode_ff ? S_PWR : S_EMIT;
            end
         end
         S_PWR: begin
            st_wr.en   = 1'b1;
            st_wr.addr = lvl_ff;
            st_wr.data = val_ff;
            pass_in    = pass_ff + PASS_BITS'(1);
            state_in   = S_PSEL;
         end
         S_CONV: begin
            st_rd.en     = src_ok;
            st_rd.addr   = src[LEVEL_BITS-1:0];
            tag_in.valid = 1'b1;
            tag_in.start = k_ff == '0;
            tag_in.zero  = !src_ok || (TAP_CNT_BITS'(k_ff) >= ks_eff);
            tag_in.coef  = tap_coef;
            if (k_ff == k_last) begin
               state_in = S_CW1;
            end else begin
               k_in = k_ff + TAP_IDX_BITS'(1);
            end
         end
         S_CW1: begin
            state_in = S_CW2;
         end
         S_CW2: begin
            state_in = S_CRND;
         end
         S_CRND: begin
            val_in    = mac_result;
            second_in = 1'b0;
            if (!adjoint_mode_ff && need_first) begin
               state_in = S_SMUL;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = val_ff;
               rsp_last_in  = lvl_is_last;
               if (lvl_is_last) begin
                  state_in = S_LOAD;
               end else begin
                  lvl_in   = lvl_ff + LEVEL_BITS'(1);
                  k_in     = '0;
                  state_in = S_CONV;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // multiplier operand selection: a tap in flight, or an edge scaling
   always_comb begin
      if (tag_ff.valid) begin
         mac_ctrl.valid = 1'b1;
         mac_ctrl.start = tag_ff.start;
         mac_a          = tag_ff.zero ? '0 : st_rd_data;
         mac_b          = tag_ff.coef;
      end else begin
         mac_ctrl.valid = state_ff == S_SMUL;
         mac_ctrl.start = 1'b1;
         mac_a          = val_ff;
         mac_b          = factor;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         load_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         tag_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         tag_ff        <= tag_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lvl_ff       <= lvl_in;
      k_ff         <= k_in;
      pass_ff      <= pass_in;
      second_ff    <= second_in;
      val_ff       <= val_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   cfe_store u_store (
      .clock   (clock),
      .wr      (st_wr),
      .rd      (st_rd),
      .rd_data (st_rd_data)
   );

   cfe_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .mac_a  (mac_a),
      .mac_b  (mac_b),
      .result (mac_result)
   );

   assign req_stall          = state_ff != S_LOAD;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_last_of_column = rsp_last_ff;

endmodule

// File: rtl/core/cfe_checker.sv
// Port-level assertions for the column FIR, bound to the top level.
module cfe_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [cfe_pkg::SAMPLE_BITS-1:0]   rsp_filtered_value,
   input logic                              rsp_last_of_column
);

   // out of reset: no result pending and ready for samples
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // a result other than the last of its column means the column is still in work
   a_busy_mid_column: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_column |-> req_stall)
      else $error("input taken while a column is being emitted");

   // a sample transfer is never followed at once by a mid-column result
   a_no_result_after_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !(rsp_valid && !rsp_last_of_column))
      else $error("mid-column result right after a sample transfer");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered_value)
         && $stable(rsp_last_of_column))
      else $error("stalled result changed");

endmodule

bind column_fir_with_edge_norm cfe_checker u_cfe_checker (.*);
